[sv/irl_pkg.sv]
// Package of the interrupt router: item types, register offsets and the clock rate table.
package irl_pkg;

  // Default and largest number of interrupt sources.
  localparam int unsigned NumSourcesDef = 24;
  localparam int unsigned NumSourcesMax = 24;

  // Kinds of input item; the fourth code is a no-operation.
  typedef enum logic [1:0] {
    KindWrite  = 2'd0,
    KindRead   = 2'd1,
    KindSource = 2'd2
  } irl_kind_e;

  // Register offsets in the window.
  localparam logic [7:0] OffClock     = 8'd0;
  localparam logic [7:0] OffScratch   = 8'd8;
  localparam logic [7:0] OffCtlBase   = 8'd16;
  localparam logic [7:0] OffCtlLast   = 8'd27;
  localparam logic [7:0] OffPendHi    = 8'd16;
  localparam logic [7:0] OffPendMid   = 8'd17;
  localparam logic [7:0] OffPendLo    = 8'd18;
  localparam logic [7:0] OffAckBase   = 8'd18;
  localparam logic [7:0] OffAckFirst  = 8'd19;
  localparam logic [7:0] OffAckLast   = 8'd25;

  // Fields of a source control nibble.
  localparam int unsigned CtlEnableBit = 3;

  // Clock control byte.
  localparam int unsigned ForceSlowBit = 7;
  localparam logic [6:0]  SlowMhz      = 7'd8;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] reg_offset;
    logic [7:0] write_data;
    logic [4:0] source_index;
    logic       source_active;
  } irl_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] level_lines;
    logic [6:0] cpu_clock_mhz;
  } irl_result_t;

  // Processor clock in MHz selected by a clock control byte.
  function automatic logic [6:0] clock_mhz(input logic [7:0] ctl);
    logic [6:0] mhz;
    unique case (ctl[6:4])
      3'd0:    mhz = 7'd33;
      3'd1:    mhz = 7'd80;
      3'd2:    mhz = 7'd66;
      3'd3:    mhz = 7'd50;
      3'd4:    mhz = 7'd40;
      3'd5:    mhz = 7'd60;
      3'd6:    mhz = 7'd25;
      default: mhz = 7'd20;
    endcase
    if (ctl[ForceSlowBit]) begin
      mhz = SlowMhz;
    end
    return mhz;
  endfunction

endpackage

[sv/irl_in_if.sv]
// Input channel of the interrupt router: valid, ready and one input item.
interface irl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] reg_offset;
  logic [7:0] write_data;
  logic [4:0] source_index;
  logic       source_active;

  modport source (
    output valid, kind, reg_offset, write_data, source_index, source_active,
    input  ready
  );
  modport sink (
    input  valid, kind, reg_offset, write_data, source_index, source_active,
    output ready
  );
endinterface

[sv/irl_out_if.sv]
// Result channel of the interrupt router: valid, ready and one result item.
interface irl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] level_lines;
  logic [6:0] cpu_clock_mhz;

  modport source (
    output valid, read_data, level_lines, cpu_clock_mhz,
    input  ready
  );
  modport sink (
    input  valid, read_data, level_lines, cpu_clock_mhz,
    output ready
  );
endinterface

[sv/irl_in_stage.sv]
// Input register of the interrupt router: holds one accepted item until it is processed.
module irl_in_stage import irl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  irl_item_t item_i,
  input  logic      take_i,
  output logic      valid_o,
  output irl_item_t item_o
);

  logic      valid_q, valid_d;
  irl_item_t item_q;

  // The register is free when empty or when its item moves on this cycle.
  assign ready_o = !valid_q || take_i;
  assign valid_d = valid_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/irl_core.sv]
// Register file and routing logic of the interrupt router: one item per cycle while go_i is high.
module irl_core import irl_pkg::*; #(
  parameter int unsigned NUM_SOURCES = NumSourcesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  irl_item_t   item_i,
  output irl_result_t res_o,
  output logic [7:0]  lines_o
);

  logic [7:0]             clock_q, clock_d;
  logic [7:0]             scratch_q [8];
  logic [7:0]             scratch_d [8];
  logic [3:0]             ctl_q [NUM_SOURCES];
  logic [3:0]             ctl_d [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] pend_q, pend_d;
  logic [7:0]             line_q, line_d;

  logic                   is_wr, is_rd, is_src, ack, src_hit;
  logic [2:0]             ack_lvl;
  logic [NUM_SOURCES-1:0] match, sel;
  logic [3:0]             sel_ctl;
  logic [23:0]            pend_ext;
  logic [7:0]             rd;
  logic [7:0]             off;

  always_comb begin
    off    = item_i.reg_offset;
    is_wr  = 1'b0;
    is_rd  = 1'b0;
    is_src = 1'b0;
    unique case (item_i.kind)
      KindWrite:  is_wr  = go_i;
      KindRead:   is_rd  = go_i;
      KindSource: is_src = go_i;
      default:    ;
    endcase

    ack     = is_rd && (off >= OffAckFirst) && (off <= OffAckLast);
    ack_lvl = 3'(off - OffAckBase);

    // Per-source routing compares and selection of the changed source.
    sel_ctl = 4'd0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      match[i] = (ctl_q[i][2:0] == ack_lvl);
      sel[i]   = (item_i.source_index == 5'(i));
      sel_ctl  = sel_ctl | (sel[i] ? ctl_q[i] : 4'd0);
    end
    src_hit = is_src && (|sel) && sel_ctl[CtlEnableBit];

    pend_d = pend_q;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (ack && match[i]) begin
        pend_d[i] = 1'b0;
      end else if (src_hit && sel[i]) begin
        pend_d[i] = item_i.source_active;
      end
    end

    line_d = line_q;
    if (ack) begin
      line_d[ack_lvl] = 1'b0;
    end
    if (src_hit) begin
      line_d[sel_ctl[2:0]] = item_i.source_active;
    end

    // Bus writes.
    clock_d = clock_q;
    if (is_wr && off == OffClock) begin
      clock_d = item_i.write_data;
    end
    for (int k = 0; k < 8; k++) begin
      scratch_d[k] = scratch_q[k];
    end
    if (is_wr && off[7:3] == OffScratch[7:3]) begin
      scratch_d[off[2:0]] = item_i.write_data;
    end
    for (int i = 0; i < NUM_SOURCES; i++) begin
      ctl_d[i] = ctl_q[i];
      if (is_wr && off <= OffCtlLast && off == OffCtlBase + 8'(i / 2)) begin
        ctl_d[i] = (i % 2 == 0) ? item_i.write_data[7:4] : item_i.write_data[3:0];
      end
    end

    // Bus reads.
    pend_ext = 24'(pend_q);
    priority if (off == OffClock) begin
      rd = clock_q;
    end else if (off[7:3] == OffScratch[7:3]) begin
      rd = scratch_q[off[2:0]];
    end else if (off == OffPendHi) begin
      rd = pend_ext[23:16];
    end else if (off == OffPendMid) begin
      rd = pend_ext[15:8];
    end else if (off == OffPendLo) begin
      rd = pend_ext[7:0];
    end else if (off >= OffAckFirst && off <= OffAckLast) begin
      rd = 8'($countones(match));
    end else begin
      rd = 8'd0;
    end

    res_o.read_data     = is_rd ? rd : 8'd0;
    res_o.level_lines   = line_d;
    res_o.cpu_clock_mhz = clock_mhz(clock_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= 8'd0;
      pend_q  <= '0;
      line_q  <= 8'd0;
      for (int k = 0; k < 8; k++) begin
        scratch_q[k] <= 8'd0;
      end
      for (int i = 0; i < NUM_SOURCES; i++) begin
        ctl_q[i] <= 4'd0;
      end
    end else begin
      clock_q <= clock_d;
      pend_q  <= pend_d;
      line_q  <= line_d;
      for (int k = 0; k < 8; k++) begin
        scratch_q[k] <= scratch_d[k];
      end
      for (int i = 0; i < NUM_SOURCES; i++) begin
        ctl_q[i] <= ctl_d[i];
      end
    end
  end

  assign lines_o = line_q;

endmodule

[sv/interrupt_router_with_level_ack.sv]
// Top level of the interrupt router with level acknowledge.
//
// The router takes one item per clock cycle: a bus write, a bus read or a
// change on one of NUM_SOURCES interrupt sources, and returns exactly one
// result item for each, in order. An accepted item first sits in the input
// register; in the next cycle in which the result register is free it goes
// through the routing logic, updates the stored state and lands in the
// result register, where it is offered to the sink until it is taken.
// Throughput is one item per cycle for as long as the sink takes
// results; the input register and the result register together let a new
// item be accepted while a finished result still waits. Each result carries
// the byte read (zero for anything but a read), the eight level lines and
// the processor clock rate as they stand after the item. Every source has a
// four-bit control (enable plus a three-bit level), written two to a byte at
// offsets 16 to 27. Reading offsets 19 to 25 acknowledges levels 1 to 7: it
// clears the pending bits of every source routed to that level, enabled or
// not, drops the level's line and returns how many sources are routed there.
// All stored state is cleared by reset; there is no clearing pass.
module interrupt_router_with_level_ack import irl_pkg::*; #(
  parameter int unsigned NUM_SOURCES = NumSourcesDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  irl_in_if.sink    in_i,
  irl_out_if.source out_o
);

  irl_item_t   in_item, item;
  logic        item_valid;
  logic        adv;
  logic        out_valid_q;
  irl_result_t res_d, res_q;
  logic [7:0]  lines;
  logic [2:0]  ack_lvl;

  assign in_item.kind          = in_i.kind;
  assign in_item.reg_offset    = in_i.reg_offset;
  assign in_item.write_data    = in_i.write_data;
  assign in_item.source_index  = in_i.source_index;
  assign in_item.source_active = in_i.source_active;

  // The item in the input register is processed when the result register
  // is empty or its result is being taken in this cycle.
  assign adv = item_valid && (!out_valid_q || out_o.ready);

  irl_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .take_i  (adv),
    .valid_o (item_valid),
    .item_o  (item)
  );

  irl_core #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (adv),
    .item_i  (item),
    .res_o   (res_d),
    .lines_o (lines)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = res_q.read_data;
  assign out_o.level_lines   = res_q.level_lines;
  assign out_o.cpu_clock_mhz = res_q.cpu_clock_mhz;

  assign ack_lvl = 3'(item.reg_offset - OffAckBase);

`ifndef SYNTHESIS
  // Only a source change can raise a level line.
  a_line_rise_by_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && item.kind != KindSource) |=> ((res_q.level_lines & ~$past(lines)) == 8'd0))
    else $error("level line rose on an item that is not a source change");

  // An acknowledge leaves its level's line dropped in the result.
  a_ack_drops_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && item.kind == KindRead && item.reg_offset >= OffAckFirst &&
     item.reg_offset <= OffAckLast) |=> !res_q.level_lines[$past(ack_lvl)])
    else $error("acknowledged level line still high");

  // A result waiting for the sink is not lost.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q)
    else $error("pending result dropped");
`endif

endmodule

[tb/irl_route_checker.sv]
// Checker of the interrupt router: predicts each result item and compares it on arrival.
`timescale 1ns / 100ps

module irl_route_checker import irl_pkg::*; #(
  parameter int unsigned NUM_SOURCES = NumSourcesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  irl_in_if    in_i,
  irl_out_if   res_i,
  output int   error_count_o,
  output int   awaited_o,
  output int   checked_o
);

  localparam logic [7:0] ScratchLast = OffScratch + 8'd7;

  // Predicted state of the router.
  logic [7:0]               clk_ctl;
  logic [7:0]               scratch [8];
  logic [3:0]               src_ctl [NumSourcesMax];
  logic [NumSourcesMax-1:0] pend;
  logic [7:0]               lines;

  irl_result_t awaited_results [$];
  irl_result_t want;
  irl_result_t got;
  irl_item_t   item;
  int          errors;
  int          checked;

  function automatic logic [6:0] rate_mhz(input logic [7:0] ctl);
    if (ctl[ForceSlowBit]) begin
      return SlowMhz;
    end
    case (ctl[6:4])
      3'd0:    return 7'd33;
      3'd1:    return 7'd80;
      3'd2:    return 7'd66;
      3'd3:    return 7'd50;
      3'd4:    return 7'd40;
      3'd5:    return 7'd60;
      3'd6:    return 7'd25;
      default: return 7'd20;
    endcase
  endfunction

  // Applies one item to the predicted state and returns the result it causes.
  function automatic irl_result_t route_item(input irl_item_t it);
    irl_result_t r;
    logic [7:0]  off;
    int unsigned base;
    int unsigned level;
    logic [7:0]  hits;
    int          i;
    r.read_data = 8'd0;
    off = it.reg_offset;
    case (it.kind)
      KindWrite: begin
        if (off == OffClock) begin
          clk_ctl = it.write_data;
        end else if (off >= OffScratch && off <= ScratchLast) begin
          scratch[off[2:0]] = it.write_data;
        end else if (off >= OffCtlBase && off <= OffCtlLast) begin
          base = 2 * (off - OffCtlBase);
          if (base < NUM_SOURCES) begin
            src_ctl[base] = it.write_data[7:4];
          end
          if (base + 1 < NUM_SOURCES) begin
            src_ctl[base + 1] = it.write_data[3:0];
          end
        end
      end
      KindRead: begin
        if (off == OffClock) begin
          r.read_data = clk_ctl;
        end else if (off >= OffScratch && off <= ScratchLast) begin
          r.read_data = scratch[off[2:0]];
        end else if (off == OffPendHi) begin
          r.read_data = pend[23:16];
        end else if (off == OffPendMid) begin
          r.read_data = pend[15:8];
        end else if (off == OffPendLo) begin
          r.read_data = pend[7:0];
        end else if (off >= OffAckFirst && off <= OffAckLast) begin
          level = off - OffAckBase;
          hits = 8'd0;
          for (i = 0; i < NUM_SOURCES; i++) begin
            if (src_ctl[i][CtlEnableBit-1:0] == level[2:0]) begin
              pend[i] = 1'b0;
              hits++;
            end
          end
          lines[level[2:0]] = 1'b0;
          r.read_data = hits;
        end
      end
      KindSource: begin
        if (it.source_index < NUM_SOURCES) begin
          if (src_ctl[it.source_index][CtlEnableBit]) begin
            pend[it.source_index] = it.source_active;
            lines[src_ctl[it.source_index][CtlEnableBit-1:0]] = it.source_active;
          end
        end
      end
      default: begin
      end
    endcase
    r.level_lines = lines;
    r.cpu_clock_mhz = rate_mhz(clk_ctl);
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clk_ctl = 8'd0;
      pend = '0;
      lines = 8'd0;
      for (int k = 0; k < 8; k++) begin
        scratch[k] = 8'd0;
      end
      for (int k = 0; k < NumSourcesMax; k++) begin
        src_ctl[k] = 4'd0;
      end
      awaited_results.delete();
      errors = 0;
      checked = 0;
    end else begin
      // A result is never taken at the edge that accepts its item, so the result is
      // retired before the item of the same edge is predicted.
      if (res_i.valid && res_i.ready) begin
        got.read_data = res_i.read_data;
        got.level_lines = res_i.level_lines;
        got.cpu_clock_mhz = res_i.cpu_clock_mhz;
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing awaited: read_data %0d level_lines %b mhz %0d",
                   $time, got.read_data, got.level_lines, got.cpu_clock_mhz);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          checked++;
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch, expected %0d, actual %0d",
                     $time, want.read_data, got.read_data);
            errors++;
          end
          if (got.level_lines !== want.level_lines) begin
            $display("%0t: level_lines mismatch, expected %b, actual %b",
                     $time, want.level_lines, got.level_lines);
            errors++;
          end
          if (got.cpu_clock_mhz !== want.cpu_clock_mhz) begin
            $display("%0t: cpu_clock_mhz mismatch, expected %0d, actual %0d",
                     $time, want.cpu_clock_mhz, got.cpu_clock_mhz);
            errors++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        item.kind = in_i.kind;
        item.reg_offset = in_i.reg_offset;
        item.write_data = in_i.write_data;
        item.source_index = in_i.source_index;
        item.source_active = in_i.source_active;
        awaited_results.push_back(route_item(item));
      end
    end
    error_count_o <= errors;
    awaited_o <= awaited_results.size();
    checked_o <= checked;
  end

endmodule

[tb/tb_interrupt_router_with_level_ack.sv]
// Testbench top of the interrupt router: clock, reset, item stimulus and the verdict.
`timescale 1ns / 100ps

module tb_interrupt_router_with_level_ack;
  import irl_pkg::*;

  // The fourth kind code does nothing; it has no member in the package enum.
  localparam logic [1:0] KindNop = 2'd3;

  // Offsets that map to nothing, used to show that they are ignored or read 0.
  localparam logic [7:0] OffGapLow    = OffClock + 8'd1;
  localparam logic [7:0] OffPastAck   = OffAckLast + 8'd1;
  localparam logic [7:0] OffPastCtl   = OffCtlLast + 8'd1;
  localparam logic [7:0] OffWindowEnd = 8'd32;
  localparam logic [7:0] OffTop       = 8'hFF;
  localparam logic [7:0] ScratchLast  = OffScratch + 8'd7;

  localparam int RandomItems = 550;
  localparam int NumPhases   = 4;
  // The limit lies well beyond what a correct run needs, even with the
  // heaviest idling.
  localparam int CycleLimit  = 200000;
  // Extra wait after the last awaited result, to catch any stray result at the end.
  localparam int DrainCycles = 10;

  logic clk_i;
  logic rst_ni;

  irl_in_if  in_if ();
  irl_out_if out_if ();

  int src_idle_pct;
  int sink_stall_pct;
  int cycle_count;
  int error_count;
  int awaited;
  int checked;
  int sent_by_kind [4];

  // Idling per phase: none, sender only, receiver only, then both lightly.
  int phase_idle  [NumPhases] = '{0, 65, 0, 18};
  int phase_stall [NumPhases] = '{0, 0, 65, 18};

  interrupt_router_with_level_ack dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  irl_route_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_if),
    .res_i         (out_if),
    .error_count_o (error_count),
    .awaited_o     (awaited),
    .checked_o     (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The run is ended here if the router stops making progress.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver decides afresh at every falling edge whether it stalls, so
  // that stalls fall on every phase of the router's work.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Offers one item, after a random number of idle cycles, and returns at the
  // falling edge after it has been accepted. The task is entered at a falling
  // edge, so valid gets at most one assignment per time step: it stays high
  // from one item to the next unless an idle cycle is drawn.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] off,
                           input logic [7:0] data, input logic [4:0] idx,
                           input logic act);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.reg_offset <= off;
    in_if.write_data <= data;
    in_if.source_index <= idx;
    in_if.source_active <= act;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    sent_by_kind[kind]++;
    @(negedge clk_i);
  endtask

  // Draws one random item. Most of them are well formed: control writes that
  // enable and route sources, changes on sources that exist, and reads of the
  // pending bytes and the acknowledge offsets. The rest is noise: unmapped
  // offsets, sources beyond the last one and no-op items.
  task automatic send_random_item();
    int unsigned pick;
    int unsigned sub;
    logic [1:0]  kind;
    logic [7:0]  off;
    logic [7:0]  data;
    logic [4:0]  idx;
    logic        act;
    pick = $urandom_range(99);
    sub = $urandom_range(9);
    off = 8'($urandom_range(255));
    data = 8'($urandom_range(255));
    idx = 5'($urandom_range(31));
    act = 1'($urandom_range(1));
    if (pick < 25) begin
      kind = KindWrite;
      if (sub < 6) begin
        off = OffCtlBase + 8'($urandom_range(11));
      end else if (sub == 6) begin
        off = OffClock;
      end else if (sub == 7) begin
        off = OffScratch + 8'($urandom_range(7));
      end
    end else if (pick < 60) begin
      kind = KindRead;
      if (sub < 4) begin
        off = OffAckFirst + 8'($urandom_range(6));
      end else if (sub < 6) begin
        off = OffPendHi + 8'($urandom_range(2));
      end else if (sub == 6) begin
        off = OffClock;
      end else if (sub == 7) begin
        off = OffScratch + 8'($urandom_range(7));
      end
    end else if (pick < 95) begin
      kind = KindSource;
      if (sub != 0) begin
        idx = 5'($urandom_range(NumSourcesDef - 1));
      end
    end else begin
      kind = KindNop;
    end
    send_item(kind, off, data, idx, act);
  endtask

  initial begin
    rst_ni = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    for (int k = 0; k < 4; k++) begin
      sent_by_kind[k] = 0;
    end
    in_if.valid = 1'b0;
    in_if.kind = KindWrite;
    in_if.reg_offset = 8'd0;
    in_if.write_data = 8'd0;
    in_if.source_index = 5'd0;
    in_if.source_active = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items, without idling. Right after reset every source sits at
    // level 0, so an acknowledge of level 1 counts nothing.
    send_item(KindRead, OffAckFirst, 8'd0, 5'd0, 1'b0);
    // Forced slow clock, then each end of the rate table.
    send_item(KindWrite, OffClock, 8'h80, 5'd0, 1'b0);
    send_item(KindRead, OffClock, 8'd0, 5'd0, 1'b0);
    send_item(KindWrite, OffClock, 8'h7F, 5'd0, 1'b0);
    send_item(KindWrite, OffClock, 8'h00, 5'd0, 1'b0);
    // Scratch bytes at both ends, read back.
    send_item(KindWrite, OffScratch, 8'hFF, 5'd0, 1'b0);
    send_item(KindWrite, ScratchLast, 8'h5A, 5'd0, 1'b0);
    send_item(KindRead, OffScratch, 8'd0, 5'd0, 1'b0);
    send_item(KindRead, ScratchLast, 8'd0, 5'd0, 1'b0);
    // Source 0 enabled at level 0 and source 1 enabled at level 1; a level 0
    // source drives line bit 0.
    send_item(KindWrite, OffCtlBase, 8'h89, 5'd0, 1'b0);
    send_item(KindSource, 8'd0, 8'd0, 5'd0, 1'b1);
    send_item(KindSource, 8'd0, 8'd0, 5'd1, 1'b1);
    send_item(KindRead, OffPendLo, 8'd0, 5'd0, 1'b0);
    send_item(KindRead, OffAckFirst, 8'd0, 5'd0, 1'b0);
    // The last control byte routes the two highest sources to level 7.
    send_item(KindWrite, OffCtlLast, 8'hFF, 5'd0, 1'b0);
    send_item(KindSource, 8'd0, 8'd0, 5'(NumSourcesDef - 1), 1'b1);
    send_item(KindRead, OffPendHi, 8'd0, 5'd0, 1'b0);
    send_item(KindRead, OffPendMid, 8'd0, 5'd0, 1'b0);
    send_item(KindRead, OffAckLast, 8'd0, 5'd0, 1'b0);
    // Changes on sources that do not exist, or that are disabled, are ignored.
    send_item(KindSource, 8'd0, 8'd0, 5'(NumSourcesDef), 1'b1);
    send_item(KindSource, 8'd0, 8'd0, 5'd31, 1'b1);
    send_item(KindSource, 8'd0, 8'd0, 5'd5, 1'b1);
    // Writes outside the map change nothing; reads outside it return zero.
    send_item(KindWrite, OffPastCtl, 8'hFF, 5'd0, 1'b0);
    send_item(KindWrite, OffWindowEnd, 8'hFF, 5'd0, 1'b0);
    send_item(KindWrite, OffTop, 8'hFF, 5'd0, 1'b0);
    send_item(KindRead, OffGapLow, 8'd0, 5'd0, 1'b0);
    send_item(KindRead, OffPastAck, 8'd0, 5'd0, 1'b0);
    send_item(KindRead, OffTop, 8'd0, 5'd0, 1'b0);
    send_item(KindNop, OffClock, 8'hFF, 5'd31, 1'b1);
    // Releasing an enabled source drops its pending bit and its line.
    send_item(KindSource, 8'd0, 8'd0, 5'd0, 1'b0);

    // Random items, a quarter of them in each idling phase.
    for (int p = 0; p < NumPhases; p++) begin
      src_idle_pct = phase_idle[p];
      sink_stall_pct = phase_stall[p];
      for (int n = 0; n < RandomItems / NumPhases; n++) begin
        send_random_item();
      end
    end

    // Stimulus is over: wait for every awaited result, then a little longer
    // so that a spurious extra result would still be seen.
    in_if.valid <= 1'b0;
    sink_stall_pct = 0;
    while (awaited != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d items: %0d writes, %0d reads, %0d source changes, %0d no-ops.",
             sent_by_kind[KindWrite] + sent_by_kind[KindRead] + sent_by_kind[KindSource]
             + sent_by_kind[KindNop], sent_by_kind[KindWrite], sent_by_kind[KindRead],
             sent_by_kind[KindSource], sent_by_kind[KindNop]);
    $display("%0d result items were checked over four idling phases; %0d mismatches.",
             checked, error_count);
    if (error_count == 0 && awaited == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
